/* rtl/cfk_pkg.sv */
// Shared types and constants for the CSV field key filter.
// No dependencies; every other file but cfk_title_mem imports this package.
package cfk_pkg;

   // Default title storage depth in bytes
   localparam int TITLE_MAX_DEFAULT = 64;
   // Longest key that can match
   localparam int KEY_BYTES = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_TEXT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GENRE_FIELD = 2'd2;

   // Register reset values
   localparam logic [63:0] KEY_TEXT_RESET    = 64'd0;
   localparam logic [3:0]  KEY_LENGTH_RESET  = 4'd1;
   localparam logic [4:0]  GENRE_FIELD_RESET = 5'd14;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_PIPE    = 8'h7C;

   // Field numbering
   localparam logic [4:0] FIELD_TITLE = 5'd1;
   localparam logic [4:0] FIELD_LAST  = 5'd31;
   localparam logic [4:0] GENRE_MIN   = 5'd2;
   localparam logic [3:0] SUB_POS_MAX = 4'd15;

   typedef struct packed {
      logic [63:0] key_text;
      logic [3:0]  key_length;
      logic [4:0]  genre_field;
   } cfg_type;

endpackage

/* rtl/cfk_title_mem.sv */
// Title byte store: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module cfk_title_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write the next title byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read on demand; hold the data otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cfk_parser.sv */
// Line parser: splits fields, matches genre subfields against the key,
// stores the title and requests emission at a matching newline. Uses cfk_pkg.
module cfk_parser
   import cfk_pkg::*;
#(
   parameter int TITLE_MAX = TITLE_MAX_DEFAULT,
   parameter int AW        = 6,
   parameter int LW        = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          byte_accept,
   input  logic [7:0]    in_byte,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          emit_start,
   output logic [AW-1:0] emit_last_idx
);

   logic          header_passed_ff, header_passed_in;
   logic [4:0]    field_number_ff, field_number_in;
   logic          field_overflow_ff, field_overflow_in;
   logic          inside_field_ff, inside_field_in;
   logic [3:0]    sub_pos_ff, sub_pos_in;
   logic          sub_mismatch_ff, sub_mismatch_in;
   logic          line_matched_ff, line_matched_in;
   logic [LW-1:0] title_length_ff, title_length_in;
   logic          genre_active;
   logic [LW-1:0] last_len;

   // A subfield matches when it is exactly the key
   function automatic logic close_hit(input logic [3:0] pos, input logic mis,
                                      input logic [3:0] klen);
      return (pos != 4'd0) && !mis && (pos == klen);
   endfunction

   assign genre_active = (cfg.genre_field >= GENRE_MIN) &&
                         (field_number_ff == cfg.genre_field) && !field_overflow_ff;

   assign wr_addr = title_length_ff[AW-1:0];
   assign wr_data = in_byte;

   // Next-state logic for one accepted byte
   always_comb begin
      logic [2:0] kidx;
      header_passed_in  = header_passed_ff;
      field_number_in   = field_number_ff;
      field_overflow_in = field_overflow_ff;
      inside_field_in   = inside_field_ff;
      sub_pos_in        = sub_pos_ff;
      sub_mismatch_in   = sub_mismatch_ff;
      line_matched_in   = line_matched_ff;
      title_length_in   = title_length_ff;
      wr_en             = 1'b0;
      emit_start        = 1'b0;
      last_len          = title_length_ff - LW'(1);
      kidx              = sub_pos_ff[2:0];

      if (byte_accept) begin
         if (!header_passed_ff) begin
            // Skip the header line
            if (in_byte == CHAR_NEWLINE) begin
               header_passed_in = 1'b1;
            end
         end else if (in_byte == CHAR_COMMA) begin
            // Close an open field; runs of commas collapse
            if (inside_field_ff) begin
               if (genre_active) begin
                  if (close_hit(sub_pos_ff, sub_mismatch_ff, cfg.key_length)) begin
                     line_matched_in = 1'b1;
                  end
                  sub_pos_in      = 4'd0;
                  sub_mismatch_in = 1'b0;
               end
               inside_field_in = 1'b0;
               if (field_number_ff < FIELD_LAST) begin
                  field_number_in = field_number_ff + 5'd1;
               end else begin
                  field_overflow_in = 1'b1;
               end
            end
         end else begin
            inside_field_in = 1'b1;
            // Store title bytes up to the limit
            if ((field_number_ff == FIELD_TITLE) && !field_overflow_ff &&
                (title_length_ff < LW'(TITLE_MAX))) begin
               wr_en           = 1'b1;
               title_length_in = title_length_ff + LW'(1);
            end
            // Compare genre subfield bytes against the key
            if (genre_active) begin
               if (in_byte == CHAR_PIPE) begin
                  if (close_hit(sub_pos_ff, sub_mismatch_ff, cfg.key_length)) begin
                     line_matched_in = 1'b1;
                  end
                  sub_pos_in      = 4'd0;
                  sub_mismatch_in = 1'b0;
               end else begin
                  if ((sub_pos_ff < cfg.key_length) && (sub_pos_ff < 4'(KEY_BYTES))) begin
                     if (cfg.key_text[{kidx, 3'b000} +: 8] != in_byte) begin
                        sub_mismatch_in = 1'b1;
                     end
                  end else begin
                     sub_mismatch_in = 1'b1;
                  end
                  if (sub_pos_ff < SUB_POS_MAX) begin
                     sub_pos_in = sub_pos_ff + 4'd1;
                  end
               end
            end
            // End of line: close the subfield, then emit if matched
            if (in_byte == CHAR_NEWLINE) begin
               if (genre_active &&
                   close_hit(sub_pos_in, sub_mismatch_in, cfg.key_length)) begin
                  line_matched_in = 1'b1;
               end
               last_len = title_length_in - LW'(1);
               if (line_matched_in && (title_length_in != '0)) begin
                  emit_start = 1'b1;
               end
            end
         end

         // Clear per-line state at each newline
         if (in_byte == CHAR_NEWLINE) begin
            field_number_in   = 5'd0;
            field_overflow_in = 1'b0;
            inside_field_in   = 1'b0;
            sub_pos_in        = 4'd0;
            sub_mismatch_in   = 1'b0;
            line_matched_in   = 1'b0;
            title_length_in   = '0;
         end
      end
   end

   assign emit_last_idx = last_len[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         header_passed_ff  <= 1'b0;
         field_number_ff   <= 5'd0;
         field_overflow_ff <= 1'b0;
         inside_field_ff   <= 1'b0;
         sub_pos_ff        <= 4'd0;
         sub_mismatch_ff   <= 1'b0;
         line_matched_ff   <= 1'b0;
         title_length_ff   <= '0;
      end else begin
         header_passed_ff  <= header_passed_in;
         field_number_ff   <= field_number_in;
         field_overflow_ff <= field_overflow_in;
         inside_field_ff   <= inside_field_in;
         sub_pos_ff        <= sub_pos_in;
         sub_mismatch_ff   <= sub_mismatch_in;
         line_matched_ff   <= line_matched_in;
         title_length_ff   <= title_length_in;
      end
   end

endmodule

/* rtl/cfk_emitter.sv */
// Title emitter: unless stalled, reads the title a byte a cycle into the
// result register, marks the last byte. Uses cfk_pkg only by convention.
module cfk_emitter
   import cfk_pkg::*;
#(
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          emit_start,
   input  logic [AW-1:0] emit_last_idx,
   input  logic          rsp_stall,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   output logic          busy,
   output logic          rsp_valid,
   output logic          rsp_last
);

   logic          busy_ff, busy_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] last_idx_ff, last_idx_in;
   logic          valid_ff, valid_in;
   logic          last_ff, last_in;

   // Issue a read whenever the result register is free or being taken
   assign rd_en   = busy_ff && (!valid_ff || !rsp_stall);
   assign rd_addr = idx_ff;

   always_comb begin
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      valid_in    = valid_ff;
      last_in     = last_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (rd_en) begin
         valid_in = 1'b1;
         last_in  = (idx_ff == last_idx_ff);
         if (idx_ff == last_idx_ff) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + AW'(1);
         end
      end
      // Load a new title; the input side is held while busy
      if (emit_start) begin
         busy_in     = 1'b1;
         idx_in      = '0;
         last_idx_in = emit_last_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      last_ff     <= last_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_last  = last_ff;

endmodule

/* rtl/csv_field_key_filter.sv */
// CSV field key filter: top level with configuration registers.
// Instantiates cfk_parser, cfk_title_mem and cfk_emitter; uses cfk_pkg.
//
// Usage:
//   req channel: one CSV text byte per transaction (req_in_byte). The first
//   line is skipped. Each later line is split on commas; the genre field is
//   split on '|' and compared with the key. At the newline of a matching
//   line the title bytes go out on the rsp channel, one per transaction,
//   with rsp_last_of_title on the final byte.
//   csr port: write key_text, key_length and genre_field while idle.
//   Throughput: one input byte per cycle when not stalled. A newline that
//   emits a title holds req_stall high while the title store is read
//   out through its single read port, one byte per cycle.
//   Readout: the newline's transaction sets the emitter busy; reads then
//   load the title bytes into the result register while rsp_stall is low.
//   rsp_stall freezes the result register and the readout; the input side
//   stays stalled until the last read is issued.
//   Reset (synchronous): clears line state, the header flag and the
//   registers to their defaults; the title store is not cleared.
module csv_field_key_filter
   import cfk_pkg::*;
#(
   parameter int TITLE_MAX = TITLE_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_title_byte,
   output logic                   rsp_last_of_title,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int AW = (TITLE_MAX > 1) ? $clog2(TITLE_MAX) : 1;
   localparam int LW = $clog2(TITLE_MAX + 1);

   cfg_type       cfg_ff;
   logic          byte_accept;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          emit_start;
   logic [AW-1:0] emit_last_idx;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          emit_busy;

   // Update configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_text    <= KEY_TEXT_RESET;
         cfg_ff.key_length  <= KEY_LENGTH_RESET;
         cfg_ff.genre_field <= GENRE_FIELD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_TEXT:    cfg_ff.key_text    <= csr_write_data;
            CSR_KEY_LENGTH:  cfg_ff.key_length  <= csr_write_data[3:0];
            CSR_GENRE_FIELD: cfg_ff.genre_field <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // Hold input while a title is read out
   assign req_stall   = emit_busy;
   assign byte_accept = req_valid && !req_stall;

   cfk_parser #(
      .TITLE_MAX (TITLE_MAX),
      .AW        (AW),
      .LW        (LW)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .byte_accept   (byte_accept),
      .in_byte       (req_in_byte),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .emit_start    (emit_start),
      .emit_last_idx (emit_last_idx)
   );

   cfk_title_mem #(
      .DEPTH (TITLE_MAX),
      .AW    (AW)
   ) u_title_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rsp_title_byte)
   );

   cfk_emitter #(
      .AW (AW)
   ) u_emitter (
      .clock         (clock),
      .reset         (reset),
      .emit_start    (emit_start),
      .emit_last_idx (emit_last_idx),
      .rsp_stall     (rsp_stall),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_last      (rsp_last_of_title)
   );

endmodule

/* rtl/cfk_checker.sv */
// Port-level checks for csv_field_key_filter, attached by bind.
// Uses cfk_pkg for the newline code.
module cfk_checker
   import cfk_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [7:0]             req_in_byte,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [7:0]             rsp_title_byte,
   input logic                   rsp_last_of_title
);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input stall only starts after an accepted newline
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |->
         $past(req_valid && !req_stall && (req_in_byte == CHAR_NEWLINE)))
      else $error("input stall without a newline");

   // Title bytes follow back to back until the last one
   a_title_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_title) |=> rsp_valid)
      else $error("gap inside a title");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_title_byte) && $stable(rsp_last_of_title)))
      else $error("stalled result changed");

endmodule

bind csv_field_key_filter cfk_checker u_cfk_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for csv_field_key_filter: drives CSV text bytes, predicts the
// emitted title bytes in a local model and compares each result transaction in order.
// Depends on rtl/cfk_pkg.sv, rtl/csv_field_key_filter.sv and its submodule files.
`timescale 1ns / 100ps

module tb_top;
   import cfk_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int MIN_TITLES   = 3;
   localparam int MAX_LINES    = 60;

   typedef struct {
      logic [7:0] title_byte;
      logic       last_flag;
   } title_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_in_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_title_byte;
   logic                   rsp_last_of_title;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Local copy of the register settings and the line parser state
   cfg_type    filter_cfg = '{KEY_TEXT_RESET, KEY_LENGTH_RESET, GENRE_FIELD_RESET};
   bit         header_done = 1'b0;
   logic [4:0] field_count = '0;
   bit         past_last_field = 1'b0;
   bit         in_field = 1'b0;
   logic [3:0] part_pos = '0;
   bit         part_miss = 1'b0;
   bit         line_hit = 1'b0;
   logic [7:0] title_buf [TITLE_MAX_DEFAULT];
   int         title_len = 0;

   title_beat_type title_queue [$];
   title_beat_type title_head;
   logic [7:0]     line_bytes [$];

   int error_count = 0;
   int bytes_sent = 0;
   int titles_predicted = 0;
   int gap_percent = 0;
   int stall_percent = 0;

   csv_field_key_filter uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_title_byte    (rsp_title_byte),
      .rsp_last_of_title (rsp_last_of_title),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // ---------------- title predictor ----------------

   function automatic bit genre_open();
      return filter_cfg.genre_field >= GENRE_MIN && field_count == filter_cfg.genre_field &&
             !past_last_field;
   endfunction

   // Close one pipe-separated genre entry; exact length and no miss means a hit
   function automatic void close_part();
      if (part_pos != 0 && !part_miss && part_pos == filter_cfg.key_length)
         line_hit = 1'b1;
      part_pos = '0;
      part_miss = 1'b0;
   endfunction

   function automatic void clear_line_state();
      field_count = '0;
      past_last_field = 1'b0;
      in_field = 1'b0;
      part_pos = '0;
      part_miss = 1'b0;
      line_hit = 1'b0;
      title_len = 0;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      title_beat_type beat;
      int i;
      if (!header_done) begin
         if (b == CHAR_NEWLINE) begin
            header_done = 1'b1;
            clear_line_state();
         end
         return;
      end
      // Comma closes an open field; runs of commas collapse
      if (b == CHAR_COMMA) begin
         if (in_field) begin
            if (genre_open())
               close_part();
            in_field = 1'b0;
            if (field_count < FIELD_LAST)
               field_count++;
            else
               past_last_field = 1'b1;
         end
         return;
      end
      in_field = 1'b1;
      if (field_count == FIELD_TITLE && !past_last_field && title_len < TITLE_MAX_DEFAULT) begin
         title_buf[title_len] = b;
         title_len++;
      end
      if (genre_open()) begin
         if (b == CHAR_PIPE) begin
            close_part();
         end else begin
            if (part_pos < filter_cfg.key_length && part_pos < KEY_BYTES) begin
               if (filter_cfg.key_text[8*part_pos +: 8] != b)
                  part_miss = 1'b1;
            end else begin
               part_miss = 1'b1;
            end
            if (part_pos < SUB_POS_MAX)
               part_pos++;
         end
      end
      // Newline: settle the open entry, queue the title on a hit
      if (b == CHAR_NEWLINE) begin
         if (genre_open())
            close_part();
         if (line_hit) begin
            for (i = 0; i < title_len; i++) begin
               beat.title_byte = title_buf[i];
               beat.last_flag = (i == title_len - 1);
               title_queue.push_back(beat);
               titles_predicted++;
            end
         end
         clear_line_state();
      end
   endfunction

   // ---------------- result checking ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_percent);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (title_queue.size() == 0) begin
            report_mismatch($sformatf("title byte %02h with nothing expected", rsp_title_byte));
         end else begin
            title_head = title_queue.pop_front();
            if (rsp_title_byte !== title_head.title_byte)
               report_mismatch($sformatf("title byte %02h, expected %02h",
                                         rsp_title_byte, title_head.title_byte));
            if (rsp_last_of_title !== title_head.last_flag)
               report_mismatch($sformatf("last_of_title %b, expected %b",
                                         rsp_last_of_title, title_head.last_flag));
         end
      end
   end

   // ---------------- drivers ----------------

   // Send one byte transaction, with random idle cycles in front of it
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < gap_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_byte(value);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_bytes.size(); i++)
         send_byte(line_bytes[i]);
   endtask

   // Drop valid and wait until every queued title has come out
   task automatic settle();
      req_valid <= 1'b0;
      while (title_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_register(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      case (index)
         CSR_KEY_TEXT:    filter_cfg.key_text = data;
         CSR_KEY_LENGTH:  filter_cfg.key_length = data[3:0];
         CSR_GENRE_FIELD: filter_cfg.genre_field = data[4:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [63:0] key, input logic [3:0] key_len,
                            input logic [4:0] genre);
      settle();
      put_register(CSR_KEY_TEXT, key);
      put_register(CSR_KEY_LENGTH, 64'(key_len));
      put_register(CSR_GENRE_FIELD, 64'(genre));
      csr_write_enable <= 1'b0;
   endtask

   // ---------------- line generation ----------------

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CHAR_COMMA || b == CHAR_PIPE || b == CHAR_NEWLINE);
      return b;
   endfunction

   function automatic void push_plain(input int count);
      int i;
      for (i = 0; i < count; i++)
         line_bytes.push_back(plain_byte());
   endfunction

   // Push the first count key bytes, never more than the key holds
   function automatic void push_key_bytes(input int count);
      int i;
      int n;
      n = (filter_cfg.key_length > KEY_BYTES) ? KEY_BYTES : filter_cfg.key_length;
      if (count < n)
         n = count;
      for (i = 0; i < n; i++)
         line_bytes.push_back(filter_cfg.key_text[8*i +: 8]);
   endfunction

   function automatic void add_genre_list(input bit sure_hit);
      int parts;
      int i;
      if (sure_hit) begin
         push_key_bytes(KEY_BYTES);
         return;
      end
      parts = $urandom_range(1, 3);
      if ($urandom_range(0, 5) == 0)
         line_bytes.push_back(CHAR_PIPE);
      for (i = 0; i < parts; i++) begin
         case ($urandom_range(0, 5))
            0, 1: push_key_bytes(KEY_BYTES);
            2: push_key_bytes(filter_cfg.key_length - 1);
            3: begin
               push_key_bytes(KEY_BYTES);
               push_plain(1);
            end
            default: push_plain($urandom_range(1, ($urandom_range(0, 7) == 0) ? 17 : 9));
         endcase
         if (i != parts - 1) begin
            line_bytes.push_back(CHAR_PIPE);
            if ($urandom_range(0, 4) == 0)
               line_bytes.push_back(CHAR_PIPE);
         end
      end
   endfunction

   // Build one line; sure hits carry the exact key, long titles fill or overrun the store
   function automatic void build_line(input bit sure_hit, input bit long_title);
      int slot;
      int n_fields;
      int f;
      line_bytes.delete();
      if (!sure_hit && $urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(0, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
         line_bytes.push_back(CHAR_NEWLINE);
         return;
      end
      slot = (filter_cfg.genre_field >= GENRE_MIN) ? filter_cfg.genre_field : GENRE_MIN;
      n_fields = slot + 1 + $urandom_range(0, 2);
      if (!sure_hit && $urandom_range(0, 9) == 0)
         n_fields = $urandom_range(1, slot);
      for (f = 0; f < n_fields; f++) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) line_bytes.push_back(CHAR_COMMA);
         if (f == FIELD_TITLE) begin
            if (long_title)
               push_plain($urandom_range(64, 70));
            else if (sure_hit)
               push_plain($urandom_range(3, 8));
            else
               push_plain($urandom_range(1, 6));
         end else if (f == slot) begin
            add_genre_list(sure_hit);
         end else if ($urandom_range(0, 3) == 0) begin
            push_key_bytes(KEY_BYTES);
         end else begin
            push_plain($urandom_range(1, 3));
         end
         if (f != n_fields - 1 || sure_hit || $urandom_range(0, 3) != 0)
            line_bytes.push_back(CHAR_COMMA);
      end
      line_bytes.push_back(CHAR_NEWLINE);
   endfunction

   // Build a short line whose genre slot holds exactly the key bytes
   function automatic void build_key_line();
      int slot;
      int f;
      line_bytes.delete();
      slot = (filter_cfg.genre_field >= GENRE_MIN) ? filter_cfg.genre_field : GENRE_MIN;
      for (f = 0; f < slot; f++) begin
         push_plain((f == FIELD_TITLE) ? 2 : 1);
         line_bytes.push_back(CHAR_COMMA);
      end
      push_key_bytes(KEY_BYTES);
      line_bytes.push_back(CHAR_COMMA);
      line_bytes.push_back(CHAR_NEWLINE);
   endfunction

   // ---------------- tests ----------------

   // Header line with separators and edge bytes, under the reset settings
   task automatic test_header_skip();
      send_byte(8'h00);
      send_text(",a|");
      send_byte(8'hFF);
      send_text("\n");
   endtask

   // Key "ab" in field 2: trailing newline, comma runs, prefix and superstring
   task automatic test_basic_match();
      configure(64'h0000_0000_0000_6261, 4'd2, GENRE_MIN);
      send_text("a,T,ab\n");
      send_text(",,a,,");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text(",x||ab,\n");
      send_text("a,Tt,abc|a,\n");
   endtask

   // Full eight-byte key of all ones, and a seven-byte prefix of it
   task automatic test_key_extremes();
      configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, GENRE_MIN);
      send_text("q,Z,");
      repeat (8) send_byte(8'hFF);
      send_text(",\n");
      send_text("q,Y,");
      repeat (7) send_byte(8'hFF);
      send_text("|,\n");
   endtask

   task automatic test_random_traffic(input int gap, input int stall,
                                      input logic [3:0] key_len, input logic [4:0] genre,
                                      input int byte_goal, input bit long_title);
      logic [63:0] key;
      int i;
      int lines;
      int first_byte;
      int first_title;
      for (i = 0; i < KEY_BYTES; i++)
         key[8*i +: 8] = plain_byte();
      configure(key, key_len, genre);
      gap_percent = gap;
      stall_percent = stall;
      first_byte = bytes_sent;
      first_title = titles_predicted;
      build_line(1'b1, long_title);
      send_line();
      lines = 1;
      while ((bytes_sent - first_byte < byte_goal || titles_predicted - first_title < MIN_TITLES)
             && lines < MAX_LINES) begin
         build_line(1'b0, 1'b0);
         send_line();
         lines++;
      end
   endtask

   // Settings that can never match: one key-carrying line under each
   task automatic test_unmatchable_settings();
      logic [63:0] key;
      int i;
      int k;
      for (i = 0; i < KEY_BYTES; i++)
         key[8*i +: 8] = plain_byte();
      for (k = 0; k < 4; k++) begin
         case (k)
            0: configure(64'h0, 4'd0, GENRE_MIN);
            1: configure(key, 4'd9, GENRE_MIN);
            2: configure(key, 4'd2, 5'd1);
            default: configure({key[63:8], CHAR_COMMA}, 4'd1, GENRE_MIN);
         endcase
         build_key_line();
         send_line();
      end
   endtask

   // A matching line without its newline must produce nothing
   task automatic test_unterminated_line();
      configure(64'h0000_0000_0000_6261, 4'd2, GENRE_MIN);
      send_text("z,Tail,ab,");
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_header_skip();
      test_basic_match();
      test_key_extremes();
      test_random_traffic(0, 0, 4'd1, GENRE_MIN, 0, 1'b0);
      test_random_traffic(71, 0, 4'd8, 5'd3, 0, 1'b0);
      test_random_traffic(0, 71, 4'($urandom_range(2, 7)), 5'($urandom_range(3, 6)), 0, 1'b1);
      test_random_traffic(19, 19, 4'd3, GENRE_MIN, 30, 1'b0);
      test_unmatchable_settings();
      test_unterminated_line();
      settle();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
